// ===== hw/rtl/humidity_temp_median_conditioner_macros.svh =====
// assertion macros for the median conditioner rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef HUMIDITY_TEMP_MEDIAN_CONDITIONER_MACROS_SVH
`define HUMIDITY_TEMP_MEDIAN_CONDITIONER_MACROS_SVH

// same-cycle implication, off during reset
`define HMC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmc same-cycle check failed");

// next-cycle implication, off during reset
`define HMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmc next-cycle check failed");

`endif

// ===== hw/rtl/hmc_pkg.sv =====
// shared types, constants and crc table for the median conditioner
// no dependencies; used by every rtl file of the block except the assertion macros header
package hmc_pkg;

	localparam int WINDOW_LEN = 5;
	localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
	localparam int RANK_W     = $clog2(WINDOW_LEN);
	localparam int MED_IDX    = WINDOW_LEN / 2;
	localparam int STAGES     = 6;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] ERR_LIMIT_RST = 8'd10;
	localparam logic [7:0] BAD_MAX = 8'hFF;

	// temperature: (17572*code - 307036160) / (65536*10), toward zero
	localparam logic [14:0]        TEMP_MUL  = 15'd17572;
	localparam logic signed [31:0] TEMP_OFS  = 32'sd307036160;
	localparam logic [12:0]        RECIP_10  = 13'd6554;
	// humidity: |1250*code - 3932160| / 65536
	localparam logic [10:0]        HUM_MUL   = 11'd1250;
	localparam logic signed [27:0] HUM_OFS   = 28'sd3932160;

	typedef logic [15:0] code_t;
	typedef logic [WINDOW_LEN-1:0][15:0] win_t;
	typedef logic [STAGES-1:0] stage_en_t;
	typedef logic signed [11:0] temp_t;
	typedef logic [10:0] hum_t;
	typedef logic [15:0][7:0] crc_cols_t;

	typedef struct packed {
		logic good;
		logic health;
		logic inval;
		logic hum_bad;
		logic temp_bad;
	} flags_t;

	// crc of a word with a single bit set, msb first, init zero
	function automatic crc_cols_t crc_cols_calc();
		crc_cols_t   cols;
		logic [7:0]  c;
		logic [15:0] w;
		for (int i = 0; i < 16; i++) begin
			w = 16'(1) << i;
			c = '0;
			for (int b = 15; b >= 0; b--) begin
				c = c ^ {w[b], 7'b0};
				c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
			end
			cols[i] = c;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_cols_calc();

endpackage

// ===== hw/rtl/hmc_if.sv =====
// valid/ready channel interfaces: sample request, result request, config write
// depends on hmc_pkg for the payload types
interface hmc_sample_if;
	import hmc_pkg::*;
	logic        valid;
	logic        ready;
	logic [15:0] hum_raw;
	logic [7:0]  hum_crc;
	logic [15:0] temp_raw;
	logic [7:0]  temp_crc;
	logic        bus_error;

	modport source (output valid, output hum_raw, output hum_crc, output temp_raw,
		output temp_crc, output bus_error, input ready);
	modport sink (input valid, input hum_raw, input hum_crc, input temp_raw,
		input temp_crc, input bus_error, output ready);
endinterface

interface hmc_result_if;
	import hmc_pkg::*;
	logic  valid;
	logic  ready;
	logic  value_valid;
	logic  sensor_ok;
	logic  invalidate;
	temp_t temp_tenths;
	hum_t  hum_tenths;
	logic  hum_crc_bad;
	logic  temp_crc_bad;

	modport source (output valid, output value_valid, output sensor_ok, output invalidate,
		output temp_tenths, output hum_tenths, output hum_crc_bad, output temp_crc_bad,
		input ready);
	modport sink (input valid, input value_valid, input sensor_ok, input invalidate,
		input temp_tenths, input hum_tenths, input hum_crc_bad, input temp_crc_bad,
		output ready);
endinterface

interface hmc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hmc_lane.sv =====
// one channel lane: crc check, median window and rank-based median pick
// depends on hmc_pkg
module hmc_lane (
	input  logic              clk,
	input  logic [15:0]       raw,
	input  logic [7:0]        crc_rx,
	input  logic              push,
	input  logic [hmc_pkg::FILL_W-1:0] fill,
	input  hmc_pkg::stage_en_t en,
	output logic              crc_bad,
	output hmc_pkg::code_t    med_s2
);
	import hmc_pkg::*;

	win_t       win_q;
	win_t       win_next;
	win_t       win_s1;
	code_t      code;
	code_t      med;
	logic [7:0] crc_calc;

	// crc is linear: xor the column of every set bit
	always_comb begin
		crc_calc = '0;
		for (int i = 0; i < 16; i++) begin
			if (raw[i]) crc_calc = crc_calc ^ CRC_COLS[i];
		end
		crc_bad = (crc_calc != crc_rx);
	end

	assign code = {raw[15:2], 2'b00};

	always_comb begin
		win_next = win_q;
		if (push) begin
			if (fill < FILL_W'(WINDOW_LEN)) begin
				// warm-up: fill this slot and all later ones
				for (int i = 0; i < WINDOW_LEN; i++) begin
					if (FILL_W'(i) >= fill) win_next[i] = code;
				end
			end else begin
				win_next = {code, win_q[WINDOW_LEN-1:1]};
			end
		end
	end

	// rank of each entry, ties broken by position; the middle rank is the median
	always_comb begin
		logic [RANK_W-1:0] rank;
		med = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if (j != i) begin
					if ((win_s1[j] < win_s1[i]) || ((win_s1[j] == win_s1[i]) && (j < i)))
						rank = rank + RANK_W'(1);
				end
			end
			if (rank == RANK_W'(MED_IDX)) med = med | win_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (push) win_q <= win_next;
		if (en[0]) win_s1 <= win_next;
		if (en[1]) med_s2 <= med;
	end

endmodule

// ===== hw/rtl/hmc_temp_conv.sv =====
// temperature median to tenths of a degree, three stages
// depends on hmc_pkg
module hmc_temp_conv (
	input  logic               clk,
	input  hmc_pkg::stage_en_t en,
	input  hmc_pkg::code_t     med_s2,
	output hmc_pkg::temp_t     temp_s5
);
	import hmc_pkg::*;

	logic [30:0]        prod_s3;
	logic signed [31:0] num;
	logic [31:0]        mag;
	logic               neg_s4;
	logic [13:0]        q_s4;
	logic [26:0]        t;
	logic [11:0]        mag12;

	always_comb begin
		num = $signed({1'b0, prod_s3}) - TEMP_OFS;
		mag = num[31] ? 32'(-num) : 32'(num);
		// floor(q/10) through the reciprocal, exact for q below 16384
		t = 27'(q_s4) * 27'(RECIP_10);
		mag12 = {1'b0, t[26:16]};
	end

	always_ff @(posedge clk) begin
		if (en[2]) prod_s3 <= 31'(TEMP_MUL) * 31'(med_s2);
		if (en[3]) begin
			neg_s4 <= num[31];
			q_s4   <= mag[29:16];
		end
		if (en[4]) temp_s5 <= temp_t'(neg_s4 ? -mag12 : mag12);
	end

endmodule

// ===== hw/rtl/hmc_hum_conv.sv =====
// humidity median to tenths of a percent, three stages
// depends on hmc_pkg
module hmc_hum_conv (
	input  logic               clk,
	input  hmc_pkg::stage_en_t en,
	input  hmc_pkg::code_t     med_s2,
	output hmc_pkg::hum_t      hum_s5
);
	import hmc_pkg::*;

	logic [26:0]        prod_s3;
	logic signed [27:0] num;
	logic [27:0]        mag;
	hum_t               hum_s4;

	always_comb begin
		num = $signed({1'b0, prod_s3}) - HUM_OFS;
		mag = num[27] ? 28'(-num) : 28'(num);
	end

	always_ff @(posedge clk) begin
		if (en[2]) prod_s3 <= 27'(HUM_MUL) * 27'(med_s2);
		if (en[3]) hum_s4 <= mag[26:16];
		if (en[4]) hum_s5 <= hum_s4;
	end

endmodule

// ===== hw/rtl/humidity_temp_median_conditioner.sv =====
// humidity/temperature sample conditioner: crc check, median-of-window, fixed-point scaling
// an accepted sample passes stages s1 to s5; output register s6 offers the result request
// throughput: one sample per cycle, set by the six-stage lane pipeline with per-stage stall
// reset (arst_n low, async): health, error count, warm-up count, held outputs cleared,
// error_limit back to 10; the window stores have no reset and are filled on the first good sample
`include "humidity_temp_median_conditioner_macros.svh"
module humidity_temp_median_conditioner (
	input  logic          clk,
	input  logic          arst_n,
	hmc_sample_if.sink    sample,
	hmc_result_if.source  result,
	hmc_cfg_if.sink       cfg
);
	import hmc_pkg::*;

	// stage valid bits and load enables, s1 at index 0 through the output register s6
	logic [STAGES-1:0] vld_q;
	stage_en_t         en;

	// channel state, updated the cycle a sample is accepted; limit_q on cfg writes
	logic [7:0]        limit_q;
	logic [7:0]        bad_q;
	logic              health_q;
	logic [FILL_W-1:0] fill_q;

	logic       accept;
	logic       hum_bad;
	logic       temp_bad;
	logic       good;
	logic       push;
	logic [7:0] bad_inc;
	logic       hit;
	flags_t     flags_new;

	flags_t flags_s1, flags_s2, flags_s3, flags_s4, flags_s5;

	code_t hum_med_s2;
	code_t temp_med_s2;
	temp_t temp_s5;
	hum_t  hum_s5;

	// last good filtered values, repeated on bad samples
	temp_t last_temp_q;
	hum_t  last_hum_q;

	// output register
	flags_t flags_s6;
	temp_t  temp_s6;
	hum_t   hum_s6;

	// a stage loads when it is empty or its successor loads, so bubbles close up
	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || result.ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign sample.ready = en[0];
	assign accept       = sample.valid && en[0];
	assign cfg.ready    = 1'b1;

	// two lanes side by side, one per channel
	hmc_lane u_hum_lane (
		.clk     (clk),
		.raw     (sample.hum_raw),
		.crc_rx  (sample.hum_crc),
		.push    (push),
		.fill    (fill_q),
		.en      (en),
		.crc_bad (hum_bad),
		.med_s2  (hum_med_s2)
	);

	hmc_lane u_temp_lane (
		.clk     (clk),
		.raw     (sample.temp_raw),
		.crc_rx  (sample.temp_crc),
		.push    (push),
		.fill    (fill_q),
		.en      (en),
		.crc_bad (temp_bad),
		.med_s2  (temp_med_s2)
	);

	hmc_temp_conv u_temp_conv (
		.clk     (clk),
		.en      (en),
		.med_s2  (temp_med_s2),
		.temp_s5 (temp_s5)
	);

	hmc_hum_conv u_hum_conv (
		.clk    (clk),
		.en     (en),
		.med_s2 (hum_med_s2),
		.hum_s5 (hum_s5)
	);

	// merge: good decision and health bookkeeping
	always_comb begin
		good    = !sample.bus_error && !hum_bad && !temp_bad;
		push    = accept && good;
		// error count saturates rather than wrapping
		bad_inc = (bad_q != BAD_MAX) ? bad_q + 8'd1 : bad_q;
		hit     = (bad_inc >= limit_q);
		flags_new.good     = good;
		flags_new.health   = good ? 1'b1 : (hit ? 1'b0 : health_q);
		flags_new.inval    = !good && hit;
		flags_new.hum_bad  = hum_bad;
		flags_new.temp_bad = temp_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			limit_q     <= ERR_LIMIT_RST;
			bad_q       <= '0;
			health_q    <= 1'b0;
			fill_q      <= '0;
			last_temp_q <= '0;
			last_hum_q  <= '0;
		end else begin
			if (cfg.valid) limit_q <= cfg.data;
			if (accept) begin
				health_q <= flags_new.health;
				if (good) begin
					bad_q <= '0;
					if (fill_q < FILL_W'(WINDOW_LEN)) fill_q <= fill_q + FILL_W'(1);
				end else begin
					bad_q <= hit ? 8'd0 : bad_inc;
				end
			end
			if (en[0]) vld_q[0] <= accept;
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
			if (en[STAGES-1] && vld_q[STAGES-2] && flags_s5.good) begin
				last_temp_q <= temp_s5;
				last_hum_q  <= hum_s5;
			end
		end
	end

	// flags ride along with the lane data; output stage picks fresh or held values
	always_ff @(posedge clk) begin
		if (en[0]) flags_s1 <= flags_new;
		if (en[1]) flags_s2 <= flags_s1;
		if (en[2]) flags_s3 <= flags_s2;
		if (en[3]) flags_s4 <= flags_s3;
		if (en[4]) flags_s5 <= flags_s4;
		if (en[5]) begin
			flags_s6 <= flags_s5;
			temp_s6  <= flags_s5.good ? temp_s5 : last_temp_q;
			hum_s6   <= flags_s5.good ? hum_s5 : last_hum_q;
		end
	end

	assign result.valid        = vld_q[STAGES-1];
	assign result.value_valid  = flags_s6.good;
	assign result.sensor_ok    = flags_s6.health;
	assign result.invalidate   = flags_s6.inval;
	assign result.temp_tenths  = temp_s6;
	assign result.hum_tenths   = hum_s6;
	assign result.hum_crc_bad  = flags_s6.hum_bad;
	assign result.temp_crc_bad = flags_s6.temp_bad;

	// an invalidate pulse always reports a failed sensor
	`HMC_ASSERT_SAME(a_inval_not_ok, result.valid && result.invalidate, !result.sensor_ok)
	// a good result comes with clean crcs and a healthy sensor
	`HMC_ASSERT_SAME(a_good_clean, result.valid && result.value_valid,
		result.sensor_ok && !result.invalidate && !result.hum_crc_bad && !result.temp_crc_bad)
	// warm-up count never runs past the window
	`HMC_ASSERT_SAME(a_fill_range, 1'b1, fill_q <= FILL_W'(WINDOW_LEN))
	// a good sample request heals the sensor
	`HMC_ASSERT_NEXT(a_good_heals, push, health_q && (bad_q == 8'd0))
	// reaching the limit clears the count and the health
	`HMC_ASSERT_NEXT(a_limit_clears, accept && !good && hit, (bad_q == 8'd0) && !health_q)

endmodule
